### src/mclp_pkg.sv
`default_nettype none

package mclp_pkg;

    // Line length limit in bytes
    localparam int unsigned LINE_MAX = 32;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned HEAD_N   = 4;

    // Characters of the command language
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STOP  = 8'h21;
    localparam logic [7:0] CH_LEFT  = 8'h6C;
    localparam logic [7:0] CH_RIGHT = 8'h72;
    localparam logic [7:0] CH_BOTH  = 8'h62;
    localparam logic [7:0] CH_QUIT  = 8'h71;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Result status codes
    localparam logic [2:0] ST_STOPPED = 3'd0;
    localparam logic [2:0] ST_SET     = 3'd1;
    localparam logic [2:0] ST_BADVAL  = 3'd2;
    localparam logic [2:0] ST_QUIT    = 3'd3;
    localparam logic [2:0] ST_SYNTAX  = 3'd4;

    // Duty = mag * 255 / 99, done as mag * (255 * 2648) >> 18 (exact for mag <= 99)
    localparam logic [19:0] DUTY_MUL   = 20'd675240;
    localparam int unsigned DUTY_SHIFT = 18;

    // Result word, first field in the lowest bits
    localparam int unsigned RES_W = 24;

endpackage

`default_nettype wire

### src/motor_command_line_parser_core.sv
// Motor command line parser core.
//
// Input channel (s_*): one ASCII command byte per transfer. Bytes are split
// into lines at a newline or after LINE_MAX bytes; a carriage return cuts the
// line short. Output channel (m_*): one result per finished line carrying the
// status, motor update flags, signed percent speed, PWM duty, direction pin
// levels and a disconnect flag. Bytes that do not finish a line give nothing.
//
// Throughput: one byte per cycle while s_tready is high. The per-byte work is a
// few compares, the line counters and one constant multiply for the duty, all combinational.
// Latency: the result of a line is on m_tdata the cycle after the byte that
// ends it is transferred, unless an earlier result still waits there.
//
// A two-entry output stage (result register plus skid register) lets the
// block keep taking bytes while one result waits; s_tready drops only while
// both entries are full, and rises again once the receiver takes a result.
//
// Reset (rst_n low, asynchronous) empties the output stage and starts a new
// empty line.
`default_nettype none

module motor_command_line_parser_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [3] update_left, [4] update_right, [12:5] speed_percent,
    // [20:13] pwm_duty, [21] pin_a_level, [22] pin_b_level, [23] disconnect
    output logic [23:0]      m_tdata
);

    localparam int unsigned CW = mclp_pkg::CNT_W;

    // Line state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          cut_seen_reg, cut_seen_next;
    logic [CW-1:0] line_length_reg, line_length_next;
    logic [7:0]    head_reg [mclp_pkg::HEAD_N];
    logic [7:0]    head_next [mclp_pkg::HEAD_N];

    // Output stage
    logic                       out_valid_reg;
    logic                       skid_valid_reg;
    logic [mclp_pkg::RES_W-1:0] out_data_reg;
    logic [mclp_pkg::RES_W-1:0] skid_data_reg;

    logic          accept;
    logic          line_done;
    logic [CW-1:0] bc_inc;
    logic          pop;

    // Decode signals
    logic [7:0]  c0, sg, d1, d2;
    logic        cmd_move, sign_ok, digits_ok;
    logic [6:0]  mag;
    logic [26:0] duty_prod;
    logic [7:0]  duty;
    logic [7:0]  speed;
    logic [2:0]  res_status;
    logic        res_upl, res_upr, res_pa, res_pb, res_disc;
    logic [7:0]  res_speed, res_duty;
    logic [mclp_pkg::RES_W-1:0] res_word;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign bc_inc   = byte_count_reg + CW'(1);

    // Advance the line state for the byte on the input
    always_comb
    begin
        for (int i = 0; i < mclp_pkg::HEAD_N; i++)
        begin
            head_next[i] = head_reg[i];
        end
        byte_count_next  = byte_count_reg;
        cut_seen_next    = cut_seen_reg;
        line_length_next = line_length_reg;
        line_done        = 1'b0;
        if (s_tdata == mclp_pkg::CH_LF)
        begin
            line_done = 1'b1;
        end
        else
        begin
            if (byte_count_reg < CW'(mclp_pkg::HEAD_N))
            begin
                head_next[byte_count_reg[1:0]] = s_tdata;
            end
            byte_count_next = bc_inc;
            if (s_tdata == mclp_pkg::CH_CR)
            begin
                cut_seen_next = 1'b1;
            end
            else if (!cut_seen_reg)
            begin
                line_length_next = line_length_reg + CW'(1);
            end
            if (bc_inc >= CW'(mclp_pkg::LINE_MAX))
            begin
                line_done = 1'b1;
            end
        end
    end

    // Decode the finished line from the updated state
    always_comb
    begin
        c0        = head_next[0];
        sg        = head_next[1];
        d1        = head_next[2];
        d2        = head_next[3];
        cmd_move  = (c0 == mclp_pkg::CH_LEFT) || (c0 == mclp_pkg::CH_RIGHT)
                    || (c0 == mclp_pkg::CH_BOTH);
        sign_ok   = (sg == mclp_pkg::CH_PLUS) || (sg == mclp_pkg::CH_MINUS);
        digits_ok = (d1 >= mclp_pkg::CH_0) && (d1 <= mclp_pkg::CH_9)
                    && (d2 >= mclp_pkg::CH_0) && (d2 <= mclp_pkg::CH_9);
        mag       = {3'b000, d1[3:0]} * 7'd10 + {3'b000, d2[3:0]};
        duty_prod = {20'd0, mag} * {7'd0, mclp_pkg::DUTY_MUL};
        duty      = duty_prod[mclp_pkg::DUTY_SHIFT +: 8];
        speed     = (sg == mclp_pkg::CH_MINUS) ? (8'd0 - {1'b0, mag}) : {1'b0, mag};

        res_status = mclp_pkg::ST_SYNTAX;
        res_upl    = 1'b0;
        res_upr    = 1'b0;
        res_speed  = 8'd0;
        res_duty   = 8'd0;
        res_pa     = 1'b0;
        res_pb     = 1'b0;
        res_disc   = 1'b1;
        if (line_length_next == CW'(1) && c0 == mclp_pkg::CH_STOP)
        begin
            res_status = mclp_pkg::ST_STOPPED;
            res_upl    = 1'b1;
            res_upr    = 1'b1;
            res_disc   = 1'b0;
        end
        else if (line_length_next == CW'(4) && cmd_move)
        begin
            res_disc = 1'b0;
            if (sign_ok && digits_ok)
            begin
                res_status = mclp_pkg::ST_SET;
                res_upl    = (c0 != mclp_pkg::CH_RIGHT);
                res_upr    = (c0 != mclp_pkg::CH_LEFT);
                res_speed  = speed;
                res_duty   = duty;
                res_pa     = (mag != 7'd0) && (sg == mclp_pkg::CH_MINUS);
                res_pb     = (mag != 7'd0) && (sg == mclp_pkg::CH_PLUS);
            end
            else
            begin
                res_status = mclp_pkg::ST_BADVAL;
            end
        end
        else if (line_length_next == CW'(1) && c0 == mclp_pkg::CH_QUIT)
        begin
            res_status = mclp_pkg::ST_QUIT;
        end
        res_word = {res_disc, res_pb, res_pa, res_duty, res_speed, res_upr, res_upl,
                    res_status};
    end

    // Hold line control state; restart the line when it is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            cut_seen_reg    <= 1'b0;
            line_length_reg <= '0;
        end
        else if (accept)
        begin
            if (line_done)
            begin
                byte_count_reg  <= '0;
                cut_seen_reg    <= 1'b0;
                line_length_reg <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                cut_seen_reg    <= cut_seen_next;
                line_length_reg <= line_length_next;
            end
        end
    end

    // Store the leading characters of the line
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < mclp_pkg::HEAD_N; i++)
            begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    // Output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && line_done)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept && line_done)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res_word;
            end
            else
            begin
                out_data_reg <= res_word;
            end
        end
    end

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < CW'(mclp_pkg::LINE_MAX))
        else $error("byte count reached the line limit without a decode");

    a_len_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= byte_count_reg)
        else $error("line length exceeds bytes taken");

    a_set_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] == mclp_pkg::ST_SET)
        |-> ((m_tdata[21] || m_tdata[22]) == (m_tdata[20:13] != 8'd0)))
        else $error("direction pins disagree with duty");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CW = mclp_pkg::CNT_W;

    // One decoded line, laid out exactly as on m_tdata (status in the lowest bits)
    typedef struct packed {
        logic              disc;
        logic              pin_b;
        logic              pin_a;
        logic [7:0]        duty;
        logic signed [7:0] speed;
        logic              upd_r;
        logic              upd_l;
        logic [2:0]        status;
    } line_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [2:0] status, [3] update_left, [4] update_right, [12:5] speed_percent,
    // [20:13] pwm_duty, [21] pin_a_level, [22] pin_b_level, [23] disconnect
    logic [23:0] m_tdata;

    // Command bytes still to send and decoded lines still to arrive
    logic [7:0]   pending_bytes[$];
    line_result_t expected_lines[$];

    // Line parser shadow state
    logic [CW-1:0] line_bytes = '0;
    logic          line_cut   = 1'b0;
    logic [CW-1:0] line_len   = '0;
    logic [7:0]    head_bytes[mclp_pkg::HEAD_N] = '{default: 8'h00};

    int   errors         = 0;
    int   bytes_accepted = 0;
    int   total_bytes    = 0;
    logic byte_xfer      = 1'b0;

    // Idle control
    int send_gap  = 0;
    int send_pct  = 10;
    int stall_cnt = 0;
    int recv_pct  = 10;
    int hold_cnt  = 0;
    bit hold_done = 1'b0;

    motor_command_line_parser_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count a mismatch and print it
    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // Decode the line held in the shadow state
    function automatic line_result_t decode_line();
        line_result_t r;
        int           mag;
        logic [7:0]   c0;
        logic [7:0]   sg;
        logic [7:0]   d1;
        logic [7:0]   d2;
        r   = '0;
        c0  = head_bytes[0];
        sg  = head_bytes[1];
        d1  = head_bytes[2];
        d2  = head_bytes[3];
        mag = 0;
        if (line_len == 1 && c0 == mclp_pkg::CH_STOP)
        begin
            r.status = mclp_pkg::ST_STOPPED;
            r.upd_l  = 1'b1;
            r.upd_r  = 1'b1;
        end
        else if (line_len == 4 && (c0 == mclp_pkg::CH_LEFT || c0 == mclp_pkg::CH_RIGHT ||
                                   c0 == mclp_pkg::CH_BOTH))
        begin
            if ((sg == mclp_pkg::CH_PLUS || sg == mclp_pkg::CH_MINUS) &&
                d1 >= mclp_pkg::CH_0 && d1 <= mclp_pkg::CH_9 &&
                d2 >= mclp_pkg::CH_0 && d2 <= mclp_pkg::CH_9)
            begin
                mag      = (int'(d1) - int'(mclp_pkg::CH_0)) * 10
                           + (int'(d2) - int'(mclp_pkg::CH_0));
                r.status = mclp_pkg::ST_SET;
                r.speed  = 8'((sg == mclp_pkg::CH_MINUS) ? -mag : mag);
                r.duty   = 8'(mag * 255 / 99);
                r.upd_l  = (c0 != mclp_pkg::CH_RIGHT);
                r.upd_r  = (c0 != mclp_pkg::CH_LEFT);
                r.pin_a  = (sg == mclp_pkg::CH_MINUS) && (mag != 0);
                r.pin_b  = (sg == mclp_pkg::CH_PLUS) && (mag != 0);
            end
            else
            begin
                r.status = mclp_pkg::ST_BADVAL;
            end
        end
        else if (line_len == 1 && c0 == mclp_pkg::CH_QUIT)
        begin
            r.status = mclp_pkg::ST_QUIT;
            r.disc   = 1'b1;
        end
        else
        begin
            r.status = mclp_pkg::ST_SYNTAX;
            r.disc   = 1'b1;
        end
        return r;
    endfunction

    // Advance the shadow parser by one byte; return 1 when a line finishes
    function automatic bit take_byte(input logic [7:0] c, output line_result_t res);
        bit done;
        done = 1'b0;
        res  = '0;
        if (c == mclp_pkg::CH_LF)
        begin
            done = 1'b1;
        end
        else
        begin
            if (line_bytes < mclp_pkg::HEAD_N)
            begin
                head_bytes[line_bytes[1:0]] = c;
            end
            line_bytes = line_bytes + CW'(1);
            if (c == mclp_pkg::CH_CR)
            begin
                line_cut = 1'b1;
            end
            else if (!line_cut)
            begin
                line_len = line_len + CW'(1);
            end
            done = (line_bytes >= mclp_pkg::LINE_MAX);
        end
        if (done)
        begin
            res        = decode_line();
            line_bytes = '0;
            line_cut   = 1'b0;
            line_len   = '0;
        end
        return done;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            pending_bytes.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == mclp_pkg::CH_LF)
        begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    function automatic logic [7:0] motor_char();
        case ($urandom_range(0, 2))
            0:       return mclp_pkg::CH_LEFT;
            1:       return mclp_pkg::CH_RIGHT;
            default: return mclp_pkg::CH_BOTH;
        endcase
    endfunction

    function automatic logic [7:0] sign_char();
        return $urandom_range(0, 1) ? mclp_pkg::CH_MINUS : mclp_pkg::CH_PLUS;
    endfunction

    function automatic logic [7:0] digit_char();
        return mclp_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // Build the whole byte stream: directed lines, then random lines
    task automatic build_stream();
        int kind;
        int n;
        push_text("!\n");
        push_text("q\n");
        push_text("l+99\n");
        push_text("r-99\n");
        push_text("b+00\n");
        push_text("\n");
        push_text("l+9a\n");
        push_text("\r\n");
        push_text("b-5\n");
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(mclp_pkg::CH_LF);

        while (pending_bytes.size() < 1250)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // well-formed speed command, sometimes cut by a carriage return
                pending_bytes.push_back(motor_char());
                pending_bytes.push_back(sign_char());
                pending_bytes.push_back(digit_char());
                pending_bytes.push_back(digit_char());
                if ($urandom_range(0, 3) == 0)
                begin
                    pending_bytes.push_back(mclp_pkg::CH_CR);
                    repeat ($urandom_range(0, 4)) pending_bytes.push_back(any_but_lf());
                end
                pending_bytes.push_back(mclp_pkg::CH_LF);
            end
            else if (kind < 60)
            begin
                // stop or quit
                pending_bytes.push_back($urandom_range(0, 1) ? mclp_pkg::CH_STOP
                                                             : mclp_pkg::CH_QUIT);
                if ($urandom_range(0, 3) == 0)
                begin
                    pending_bytes.push_back(mclp_pkg::CH_CR);
                    repeat ($urandom_range(0, 3)) pending_bytes.push_back(any_but_lf());
                end
                pending_bytes.push_back(mclp_pkg::CH_LF);
            end
            else if (kind < 70)
            begin
                // four bytes, the sign and each digit either valid or a random byte
                pending_bytes.push_back(motor_char());
                pending_bytes.push_back($urandom_range(0, 1) ? sign_char() : any_but_lf());
                pending_bytes.push_back($urandom_range(0, 1) ? digit_char() : any_but_lf());
                pending_bytes.push_back($urandom_range(0, 1) ? digit_char() : any_but_lf());
                pending_bytes.push_back(mclp_pkg::CH_LF);
            end
            else if (kind < 76)
            begin
                // speed command one digit short or one too long
                pending_bytes.push_back(motor_char());
                pending_bytes.push_back(sign_char());
                n = $urandom_range(0, 1) ? 1 : 3;
                repeat (n) pending_bytes.push_back(digit_char());
                pending_bytes.push_back(mclp_pkg::CH_LF);
            end
            else if (kind < 82)
            begin
                // line that runs to the length limit
                n = 0;
                if ($urandom_range(0, 1))
                begin
                    pending_bytes.push_back(motor_char());
                    pending_bytes.push_back(sign_char());
                    pending_bytes.push_back(digit_char());
                    pending_bytes.push_back(digit_char());
                    pending_bytes.push_back(mclp_pkg::CH_CR);
                    n = 5;
                end
                repeat (mclp_pkg::LINE_MAX - n) pending_bytes.push_back(any_but_lf());
                if ($urandom_range(0, 1))
                begin
                    pending_bytes.push_back(mclp_pkg::CH_LF);
                end
            end
            else
            begin
                // noise
                repeat ($urandom_range(0, 8))
                begin
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
                end
                pending_bytes.push_back(mclp_pkg::CH_LF);
            end
        end
    endtask

    // Sender: present bytes at the falling edge, idle in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || byte_xfer))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (bytes_accepted + 150 < total_bytes &&
                     $urandom_range(0, 99) < send_pct)
            begin
                send_gap <= $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                s_tdata  <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 149) == 0)
                begin
                    send_pct <= $urandom_range(0, 2) * 8;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off, otherwise random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && bytes_accepted >= 600)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 299;
            m_tready  <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end
        else if (bytes_accepted + 150 < total_bytes && $urandom_range(0, 99) < recv_pct)
        begin
            stall_cnt <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
            if ($urandom_range(0, 19) == 0)
            begin
                recv_pct <= $urandom_range(0, 3) * 10;
            end
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check results and predict from accepted bytes at the rising edge
    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t want;
        line_result_t res;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = line_result_t'(m_tdata);
                if (expected_lines.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("status", got.status, want.status);
                    check_field("update_left", got.upd_l, want.upd_l);
                    check_field("update_right", got.upd_r, want.upd_r);
                    check_field("speed_percent", int'(got.speed), int'(want.speed));
                    check_field("pwm_duty", got.duty, want.duty);
                    check_field("pin_a_level", got.pin_a, want.pin_a);
                    check_field("pin_b_level", got.pin_b, want.pin_b);
                    check_field("disconnect", got.disc, want.disc);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (take_byte(s_tdata, res))
                begin
                    expected_lines.push_back(res);
                end
                bytes_accepted <= bytes_accepted + 1;
            end
            byte_xfer <= s_tvalid && s_tready;
        end
    end

    // Main sequence: stream setup, reset, drain, verdict
    initial
    begin
        int waited;
        build_stream();
        total_bytes = pending_bytes.size();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid)
        begin
            @(negedge clk);
        end
        waited = 0;
        while (expected_lines.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (expected_lines.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_lines.size()));
        end
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
